// ===== hdl/rmhps_pkg.sv =====
// Shared types, codes and constants of the ramp, move and hold profile sampler.
// No dependencies; every other file of the block imports this package.
package rmhps_pkg;

    // Input modes.
    localparam logic [1:0] MODE_PLAN    = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;

    // Frame phases.
    localparam logic [2:0] PH_RAMP_IN   = 3'd0;
    localparam logic [2:0] PH_MOVE_OUT  = 3'd1;
    localparam logic [2:0] PH_HOLD      = 3'd2;
    localparam logic [2:0] PH_MOVE_BACK = 3'd3;
    localparam logic [2:0] PH_RAMP_OUT  = 3'd4;
    localparam logic [2:0] PH_COMPLETE  = 3'd5;
    localparam logic [2:0] PH_RELEASE   = 3'd6;
    localparam logic [2:0] PH_FAULT     = 3'd7;

    // Configuration register indices.
    localparam logic [2:0] REG_PEAK_WEIGHT  = 3'd0;
    localparam logic [2:0] REG_WEIGHT_RATE  = 3'd1;
    localparam logic [2:0] REG_JOINT_OFFSET = 3'd2;
    localparam logic [2:0] REG_MAX_VELOCITY = 3'd3;
    localparam logic [2:0] REG_HOLD_TIME    = 3'd4;
    localparam logic [2:0] REG_RAMP_TIME    = 3'd5;
    localparam logic [2:0] REG_MOVE_TIME    = 3'd6;

    // Microseconds per second, used to scale a limit into product units.
    localparam logic [19:0] US_PER_S = 20'd1000000;

    // Division by one million is a shift by six and a division by 15625.
    // The quotient word is below 2^38 whenever the result is not clamped,
    // so a 39 bit reciprocal with a shift of 52 gives the exact floor.
    localparam int unsigned  DIV_SHIFT = 52;
    localparam logic [38:0]  DIV_RECIP = 39'((64'd1 << DIV_SHIFT) / 64'd15625 + 64'd1);

    // Division by one thousand: shift by three, then divide by 125 through
    // a reciprocal with a shift of 30 (exact for a 23 bit dividend).
    localparam int unsigned  MS_SHIFT = 30;
    localparam logic [23:0]  MS_RECIP = 24'((64'd1 << MS_SHIFT) / 64'd125 + 64'd1);

    typedef struct packed {
        logic [14:0] peak_weight;
        logic [12:0] weight_rate;
        logic [23:0] joint_offset;
        logic [22:0] max_velocity;
        logic [20:0] hold_time_us;
        logic [24:0] ramp_time_us;
        logic [24:0] move_time_us;
    } cfg_t;

    // Phase end times; the last one stays below 2^28.
    typedef struct packed {
        logic [27:0] r_end;
        logic [27:0] m_end;
        logic [27:0] h_end;
        logic [27:0] b_end;
        logic [27:0] e_end;
    } ends_t;

    // Item context carried alongside the arithmetic.
    typedef struct packed {
        logic [2:0]  phase;
        logic        neg;
        logic [25:0] t;
        logic [14:0] prev;
        logic [31:0] seq_in;
    } ctx_t;

    // Operands for the shared scaled product: min(lim, floor(mult*dt/1e6)).
    typedef struct packed {
        ctx_t        ctx;
        logic [25:0] dt;
        logic [22:0] mult;
        logic [23:0] lim;
    } sel_t;

    typedef struct packed {
        ctx_t        ctx;
        logic [23:0] dm;
        logic [16:0] seq_plan;
    } res_t;

endpackage

// ===== hdl/rmhps_cfg.sv =====
// Configuration registers of the profile sampler and the derived phase end times.
// Depends on rmhps_pkg.
module rmhps_cfg
    import rmhps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg,
    output ends_t       ends
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    ends_t ends_reg;
    ends_t ends_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PEAK_WEIGHT:  cfg_next.peak_weight  = cfg_data[14:0];
                REG_WEIGHT_RATE:  cfg_next.weight_rate  = cfg_data[12:0];
                REG_JOINT_OFFSET: cfg_next.joint_offset = cfg_data[23:0];
                REG_MAX_VELOCITY: cfg_next.max_velocity = cfg_data[22:0];
                REG_HOLD_TIME:    cfg_next.hold_time_us = cfg_data[20:0];
                REG_RAMP_TIME:    cfg_next.ramp_time_us = cfg_data[24:0];
                REG_MOVE_TIME:    cfg_next.move_time_us = cfg_data[24:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Configuration only changes while no item is in flight, so the end
    // times may be registered and trail the registers.
    always_comb
    begin
        ends_next.r_end = 28'(cfg_reg.ramp_time_us);
        ends_next.m_end = 28'(cfg_reg.ramp_time_us) + 28'(cfg_reg.move_time_us);
        ends_next.h_end = 28'(cfg_reg.ramp_time_us) + 28'(cfg_reg.move_time_us)
                        + 28'(cfg_reg.hold_time_us);
        ends_next.b_end = 28'(cfg_reg.ramp_time_us) + {2'b0, cfg_reg.move_time_us, 1'b0}
                        + 28'(cfg_reg.hold_time_us);
        ends_next.e_end = {2'b0, cfg_reg.ramp_time_us, 1'b0}
                        + {2'b0, cfg_reg.move_time_us, 1'b0}
                        + 28'(cfg_reg.hold_time_us);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ends_reg <= '0;
        end
        else
        begin
            ends_reg <= ends_next;
        end
    end

    assign cfg  = cfg_reg;
    assign ends = ends_reg;

endmodule

// ===== hdl/rmhps_phase.sv =====
// Input stage and phase decode: picks the phase and the operands of the scaled product.
// Depends on rmhps_pkg.
module rmhps_phase
    import rmhps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  mode,
    input  logic [25:0] elapsed_us,
    input  logic [14:0] prev_weight,
    input  logic [31:0] sequence_in,
    input  cfg_t        cfg,
    input  ends_t       ends,
    output logic        sel_valid,
    output sel_t        sel,
    output logic        in_flight
);

    logic        a_valid_reg;
    logic [1:0]  a_mode_reg;
    logic [25:0] a_t_reg;
    logic [14:0] a_prev_reg;
    logic [31:0] a_seq_reg;

    logic        b_valid_reg;
    sel_t        sel_reg;
    sel_t        sel_next;

    logic [27:0] t28;
    logic [23:0] mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mode_reg <= mode;
        a_t_reg    <= elapsed_us;
        a_prev_reg <= prev_weight;
        a_seq_reg  <= sequence_in;
        sel_reg    <= sel_next;
    end

    assign t28 = {2'b0, a_t_reg};
    // Magnitude of the offset; the most negative code gives 2^23, which fits.
    assign mag = cfg.joint_offset[23] ? 24'(-cfg.joint_offset) : cfg.joint_offset;

    always_comb
    begin
        sel_next.ctx.neg    = cfg.joint_offset[23];
        sel_next.ctx.t      = a_t_reg;
        sel_next.ctx.prev   = a_prev_reg;
        sel_next.ctx.seq_in = a_seq_reg;
        sel_next.ctx.phase  = PH_FAULT;
        sel_next.dt         = '0;
        sel_next.mult       = '0;
        sel_next.lim        = '0;
        if (a_mode_reg == MODE_PLAN)
        begin
            if (t28 < ends.r_end)
            begin
                sel_next.ctx.phase = PH_RAMP_IN;
                sel_next.dt        = a_t_reg;
                sel_next.mult      = 23'(cfg.weight_rate);
                sel_next.lim       = 24'(cfg.peak_weight);
            end
            else if (t28 < ends.m_end)
            begin
                sel_next.ctx.phase = PH_MOVE_OUT;
                sel_next.dt        = 26'(t28 - ends.r_end);
                sel_next.mult      = cfg.max_velocity;
                sel_next.lim       = mag;
            end
            else if (t28 < ends.h_end)
            begin
                sel_next.ctx.phase = PH_HOLD;
            end
            else if (t28 < ends.b_end)
            begin
                sel_next.ctx.phase = PH_MOVE_BACK;
                sel_next.dt        = 26'(t28 - ends.h_end);
                sel_next.mult      = cfg.max_velocity;
                sel_next.lim       = mag;
            end
            else if (t28 < ends.e_end)
            begin
                sel_next.ctx.phase = PH_RAMP_OUT;
                sel_next.dt        = 26'(t28 - ends.b_end);
                sel_next.mult      = 23'(cfg.weight_rate);
                sel_next.lim       = 24'(cfg.peak_weight);
            end
            else
            begin
                sel_next.ctx.phase = PH_COMPLETE;
            end
        end
        else if (a_mode_reg == MODE_RELEASE)
        begin
            sel_next.ctx.phase = PH_RELEASE;
            sel_next.dt        = a_t_reg;
            sel_next.mult      = 23'(cfg.weight_rate);
            sel_next.lim       = 24'(a_prev_reg);
        end
    end

    assign sel_valid = b_valid_reg;
    assign sel       = sel_reg;
    assign in_flight = a_valid_reg | b_valid_reg;

endmodule

// ===== hdl/rmhps_scale.sv =====
// Three stage datapath for min(lim, floor(mult * dt / 1e6)) and the millisecond count.
// Depends on rmhps_pkg.
module rmhps_scale
    import rmhps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic sel_valid,
    input  sel_t sel,
    output logic res_valid,
    output res_t res,
    output logic in_flight
);

    // First stage: products.
    logic        c_valid_reg;
    ctx_t        c_ctx_reg;
    logic [23:0] c_lim_reg;
    logic [48:0] c_prod_reg;
    logic [43:0] c_limx_reg;
    logic [46:0] c_ms_reg;

    // Second stage: clamp decision and reciprocal partial products.
    logic        d_valid_reg;
    ctx_t        d_ctx_reg;
    logic [23:0] d_lim_reg;
    logic        d_clamp_reg;
    logic [57:0] d_pp_lo_reg;
    logic [56:0] d_pp_hi_reg;
    logic [16:0] d_seq_reg;

    // Third stage: quotient and clamp.
    logic        e_valid_reg;
    res_t        e_res_reg;

    logic [37:0] quot_in;
    logic [76:0] recip_sum;
    logic [23:0] quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= sel_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // When the product is below lim * 1e6 the word after the shift by six
    // is below 2^38; otherwise the quotient is not used.
    assign quot_in   = c_prod_reg[43:6];
    assign recip_sum = {d_pp_hi_reg, 20'b0} + 77'(d_pp_lo_reg);
    assign quot      = recip_sum[DIV_SHIFT+23:DIV_SHIFT];

    always_ff @(posedge clk)
    begin
        c_ctx_reg   <= sel.ctx;
        c_lim_reg   <= sel.lim;
        c_prod_reg  <= 49'(sel.mult) * 49'(sel.dt);
        c_limx_reg  <= 44'(sel.lim) * 44'(US_PER_S);
        c_ms_reg    <= 47'(sel.ctx.t[25:3]) * 47'(MS_RECIP);

        d_ctx_reg   <= c_ctx_reg;
        d_lim_reg   <= c_lim_reg;
        d_clamp_reg <= c_prod_reg >= 49'(c_limx_reg);
        d_pp_lo_reg <= 58'(quot_in) * 58'(DIV_RECIP[19:0]);
        d_pp_hi_reg <= 57'(quot_in) * 57'(DIV_RECIP[38:20]);
        d_seq_reg   <= c_ms_reg[MS_SHIFT+16:MS_SHIFT] + 17'd1;

        e_res_reg.ctx      <= d_ctx_reg;
        e_res_reg.dm       <= d_clamp_reg ? d_lim_reg : quot;
        e_res_reg.seq_plan <= d_seq_reg;
    end

    assign res_valid = e_valid_reg;
    assign res       = e_res_reg;
    assign in_flight = c_valid_reg | d_valid_reg | e_valid_reg;

endmodule

// ===== hdl/rmhps_out.sv =====
// Output stage: forms weight, angle, sequence and terminal flag and registers the frame.
// Depends on rmhps_pkg.
module rmhps_out
    import rmhps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  res_t               res,
    input  cfg_t               cfg,
    output logic               done,
    output logic [2:0]         phase,
    output logic [14:0]        weight,
    output logic signed [23:0] angle_offset,
    output logic [31:0]        sequence_out,
    output logic [25:0]        elapsed_out,
    output logic               terminal
);

    logic        done_reg;
    logic [2:0]  phase_reg;
    logic [14:0] weight_reg;
    logic [14:0] weight_next;
    logic [23:0] angle_reg;
    logic [23:0] angle_next;
    logic [31:0] seq_reg;
    logic [31:0] seq_next;
    logic [25:0] elapsed_reg;
    logic [25:0] elapsed_next;
    logic        term_reg;
    logic        term_next;

    logic [23:0] travel;

    // Signed travel along the direction of the offset.
    assign travel = res.ctx.neg ? 24'(-res.dm) : res.dm;

    always_comb
    begin
        weight_next  = '0;
        angle_next   = '0;
        seq_next     = 32'(res.seq_plan);
        elapsed_next = res.ctx.t;
        term_next    = 1'b0;
        unique case (res.ctx.phase)
            PH_RAMP_IN:
            begin
                weight_next = res.dm[14:0];
            end
            PH_MOVE_OUT:
            begin
                weight_next = cfg.peak_weight;
                angle_next  = travel;
            end
            PH_HOLD:
            begin
                weight_next = cfg.peak_weight;
                angle_next  = cfg.joint_offset;
            end
            PH_MOVE_BACK:
            begin
                weight_next = cfg.peak_weight;
                angle_next  = cfg.joint_offset - travel;
            end
            PH_RAMP_OUT:
            begin
                weight_next = cfg.peak_weight - res.dm[14:0];
            end
            PH_COMPLETE:
            begin
                term_next = 1'b1;
            end
            PH_RELEASE:
            begin
                weight_next = res.ctx.prev - res.dm[14:0];
                term_next   = (res.ctx.prev == res.dm[14:0]);
                seq_next    = res.ctx.seq_in;
            end
            PH_FAULT:
            begin
                term_next    = 1'b1;
                seq_next     = res.ctx.seq_in;
                elapsed_next = '0;
            end
            default:
            begin
                term_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg   <= res.ctx.phase;
        weight_reg  <= weight_next;
        angle_reg   <= angle_next;
        seq_reg     <= seq_next;
        elapsed_reg <= elapsed_next;
        term_reg    <= term_next;
    end

    assign done         = done_reg;
    assign phase        = phase_reg;
    assign weight       = weight_reg;
    assign angle_offset = $signed(angle_reg);
    assign sequence_out = seq_reg;
    assign elapsed_out  = elapsed_reg;
    assign terminal     = term_reg;

endmodule

// ===== hdl/ramp_move_hold_profile_sampler.sv =====
// Top level of the ramp, move and hold profile sampler.
// Depends on rmhps_pkg, rmhps_cfg, rmhps_phase, rmhps_scale and rmhps_out.
//
//   Channel   Handshake               Payload
//   input     start, busy             mode, elapsed_us, prev_weight, sequence_in
//   result    done (strobe)           phase, weight, angle_offset, sequence_out,
//                                     elapsed_out, terminal
//   config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One item is taken in every cycle; busy stays low. cfg_ready is low while start
// is high or any item is still in the pipe, so a register write never meets an item.
// Each transfer gives exactly one result, marked by done. Between the accepting
// edge and done lie the input and decode registers, the scaled product (one
// stage of multipliers, one of reciprocal partial products, one of the sum) and the output register.
// Reset clears the configuration registers and every valid bit of the pipe.
// The receiver cannot stall, so nothing in the pipe ever waits.
module ramp_move_hold_profile_sampler
    import rmhps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [25:0]        elapsed_us,
    input  logic [14:0]        prev_weight,
    input  logic [31:0]        sequence_in,
    output logic               done,
    output logic [2:0]         phase,
    output logic [14:0]        weight,
    output logic signed [23:0] angle_offset,
    output logic [31:0]        sequence_out,
    output logic [25:0]        elapsed_out,
    output logic               terminal,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cfg_t  cfg;
    ends_t ends;
    logic  sel_valid;
    sel_t  sel;
    logic  res_valid;
    res_t  res;
    logic  phase_in_flight;
    logic  scale_in_flight;
    logic  cfg_write;

    assign busy      = 1'b0;
    assign cfg_ready = !(start | phase_in_flight | scale_in_flight);
    assign cfg_write = cfg_valid & cfg_ready;

    rmhps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .ends      (ends)
    );

    rmhps_phase u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .mode        (mode),
        .elapsed_us  (elapsed_us),
        .prev_weight (prev_weight),
        .sequence_in (sequence_in),
        .cfg         (cfg),
        .ends        (ends),
        .sel_valid   (sel_valid),
        .sel         (sel),
        .in_flight   (phase_in_flight)
    );

    rmhps_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .sel_valid (sel_valid),
        .sel       (sel),
        .res_valid (res_valid),
        .res       (res),
        .in_flight (scale_in_flight)
    );

    rmhps_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .cfg          (cfg),
        .done         (done),
        .phase        (phase),
        .weight       (weight),
        .angle_offset (angle_offset),
        .sequence_out (sequence_out),
        .elapsed_out  (elapsed_out),
        .terminal     (terminal)
    );

endmodule

// ===== sim/rmhps_frame_checker.sv =====
// Frame checker for the ramp, move and hold profile sampler: follows register writes,
// predicts one frame per accepted item and compares it with each result strobe.
// Depends on rmhps_pkg.
`timescale 1ns / 100ps
module rmhps_frame_checker
    import rmhps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         mode,
    input  logic [25:0]        elapsed_us,
    input  logic [14:0]        prev_weight,
    input  logic [31:0]        sequence_in,
    input  logic               done,
    input  logic [2:0]         phase,
    input  logic [14:0]        weight,
    input  logic signed [23:0] angle_offset,
    input  logic [31:0]        sequence_out,
    input  logic [25:0]        elapsed_out,
    input  logic               terminal,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int unsigned        mismatches,
    output int unsigned        outstanding
);

    typedef struct packed {
        logic [2:0]  phase;
        logic [14:0] weight;
        logic [23:0] angle;
        logic [31:0] seq;
        logic [25:0] elapsed;
        logic        terminal;
    } frame_t;

    cfg_t   regs;
    frame_t frames_due[$];
    frame_t due;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        regs        = '0;
    end

    function automatic longint unsigned per_second(input longint unsigned rate,
                                                   input longint unsigned dt);
        return (rate * dt) / 64'd1000000;
    endfunction

    // Distance covered after dt, carrying the sign of the offset and never beyond it.
    function automatic longint travel(input longint off, input longint unsigned dt);
        longint unsigned mag;
        longint unsigned reach;
        mag   = (off < 0) ? -off : off;
        reach = per_second(regs.max_velocity, dt);
        if (reach > mag)
            reach = mag;
        return (off < 0) ? -longint'(reach) : longint'(reach);
    endfunction

    function automatic frame_t plan_frame(input logic [1:0]  md,
                                          input logic [25:0] t_in,
                                          input logic [14:0] prev,
                                          input logic [31:0] seq_in);
        frame_t          f;
        longint unsigned t;
        longint unsigned r_end;
        longint unsigned m_end;
        longint unsigned h_end;
        longint unsigned b_end;
        longint unsigned e_end;
        longint unsigned fall;
        longint unsigned w;
        longint          off;
        longint          ang;
        t         = t_in;
        off       = $signed(regs.joint_offset);
        ang       = 0;
        w         = 0;
        f         = '0;
        f.seq     = seq_in;
        f.elapsed = t_in;
        case (md)
            MODE_PLAN:
            begin
                r_end = regs.ramp_time_us;
                m_end = r_end + regs.move_time_us;
                h_end = m_end + regs.hold_time_us;
                b_end = h_end + regs.move_time_us;
                e_end = b_end + regs.ramp_time_us;
                if (t < r_end)
                begin
                    f.phase = PH_RAMP_IN;
                    w       = per_second(regs.weight_rate, t);
                end
                else if (t < m_end)
                begin
                    f.phase = PH_MOVE_OUT;
                    w       = regs.peak_weight;
                    ang     = travel(off, t - r_end);
                end
                else if (t < h_end)
                begin
                    f.phase = PH_HOLD;
                    w       = regs.peak_weight;
                    ang     = off;
                end
                else if (t < b_end)
                begin
                    f.phase = PH_MOVE_BACK;
                    w       = regs.peak_weight;
                    ang     = off - travel(off, t - h_end);
                end
                else if (t < e_end)
                begin
                    f.phase = PH_RAMP_OUT;
                    fall    = per_second(regs.weight_rate, t - b_end);
                    w       = (fall >= regs.peak_weight) ? 0 : regs.peak_weight - fall;
                end
                else
                begin
                    f.phase    = PH_COMPLETE;
                    f.terminal = 1'b1;
                end
                if (w > regs.peak_weight)
                    w = regs.peak_weight;
                f.seq = 32'(t / 1000 + 1);
            end
            MODE_RELEASE:
            begin
                f.phase    = PH_RELEASE;
                fall       = per_second(regs.weight_rate, t);
                w          = (fall >= prev) ? 0 : prev - fall;
                f.terminal = (w == 0);
            end
            default:
            begin
                // The spare mode code is treated as a fault as well.
                f.phase    = PH_FAULT;
                f.terminal = 1'b1;
                f.elapsed  = '0;
            end
        endcase
        f.weight = w[14:0];
        f.angle  = ang[23:0];
        return f;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = '0;
            frames_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("result strobe with no frame outstanding");
                    mismatches++;
                end
                else
                begin
                    due = frames_due.pop_front();
                    check_field("phase", due.phase, phase);
                    check_field("weight", due.weight, weight);
                    check_field("angle_offset", $signed(due.angle), angle_offset);
                    check_field("sequence_out", due.seq, sequence_out);
                    check_field("elapsed_out", due.elapsed, elapsed_out);
                    check_field("terminal", due.terminal, terminal);
                end
            end
            if (start && !busy)
                frames_due.insert(frames_due.size(),
                                  plan_frame(mode, elapsed_us, prev_weight, sequence_in));
            // A register written on this edge applies to items from the next edge on.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PEAK_WEIGHT:  regs.peak_weight  = cfg_data[14:0];
                    REG_WEIGHT_RATE:  regs.weight_rate  = cfg_data[12:0];
                    REG_JOINT_OFFSET: regs.joint_offset = cfg_data[23:0];
                    REG_MAX_VELOCITY: regs.max_velocity = cfg_data[22:0];
                    REG_HOLD_TIME:    regs.hold_time_us = cfg_data[20:0];
                    REG_RAMP_TIME:    regs.ramp_time_us = cfg_data[24:0];
                    REG_MOVE_TIME:    regs.move_time_us = cfg_data[24:0];
                    default:          ;
                endcase
            end
            outstanding = frames_due.size();
        end
    end

endmodule

// ===== sim/tb_ramp_move_hold_profile_sampler.sv =====
// Top of the profile sampler testbench: clock, reset, register settings and item stimulus.
// Depends on rmhps_pkg, the sampler RTL and rmhps_frame_checker.
`timescale 1ns / 100ps
module tb_ramp_move_hold_profile_sampler;
    import rmhps_pkg::*;

    localparam logic [1:0] MODE_FAULT = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0] REG_NONE   = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic [25:0]        elapsed_us;
    logic [14:0]        prev_weight;
    logic [31:0]        sequence_in;
    logic               done;
    logic [2:0]         phase;
    logic [14:0]        weight;
    logic signed [23:0] angle_offset;
    logic [31:0]        sequence_out;
    logic [25:0]        elapsed_out;
    logic               terminal;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    int unsigned        mismatches;
    int unsigned        outstanding;

    // Copy of the current setting, used only to aim elapsed times at phase boundaries.
    cfg_t plan;
    int   items_sent      = 0;
    int   writes_done     = 0;
    int   settings_loaded = 0;

    ramp_move_hold_profile_sampler DUT (.*);

    rmhps_frame_checker u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned phase_end(input int k);
        longint unsigned e;
        e = plan.ramp_time_us;
        if (k >= 1)
            e += plan.move_time_us;
        if (k >= 2)
            e += plan.hold_time_us;
        if (k >= 3)
            e += plan.move_time_us;
        if (k >= 4)
            e += plan.ramp_time_us;
        return e;
    endfunction

    function automatic logic [25:0] clip_us(input longint v);
        if (v < 0)
            return '0;
        if (v > 64'd67108863)
            return '1;
        return 26'(v);
    endfunction

    task automatic send_item(input logic [1:0]  md,
                             input logic [25:0] t,
                             input logic [14:0] pw,
                             input logic [31:0] sq);
        @(negedge clk);
        start       <= 1'b1;
        mode        <= md;
        elapsed_us  <= t;
        prev_weight <= pw;
        sequence_in <= sq;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    // Drops start and scrambles the payload, which must be ignored while start is low.
    task automatic pause_items(input int cycles);
        @(negedge clk);
        start       <= 1'b0;
        mode        <= 2'($urandom);
        elapsed_us  <= 26'($urandom);
        prev_weight <= 15'($urandom);
        sequence_in <= $urandom;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        writes_done++;
    endtask

    // Waits for the pipe to drain, then writes every register with junk above its width.
    task automatic load_setting(input cfg_t s);
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        write_reg(REG_PEAK_WEIGHT,  {17'($urandom), s.peak_weight});
        write_reg(REG_WEIGHT_RATE,  {19'($urandom), s.weight_rate});
        write_reg(REG_JOINT_OFFSET, {8'($urandom),  s.joint_offset});
        write_reg(REG_MAX_VELOCITY, {9'($urandom),  s.max_velocity});
        write_reg(REG_HOLD_TIME,    {11'($urandom), s.hold_time_us});
        write_reg(REG_RAMP_TIME,    {7'($urandom),  s.ramp_time_us});
        write_reg(REG_MOVE_TIME,    {7'($urandom),  s.move_time_us});
        write_reg(REG_NONE, $urandom);
        @(negedge clk);
        cfg_valid <= 1'b0;
        plan = s;
        settings_loaded++;
    endtask

    task automatic random_item;
        logic [1:0]  md;
        logic [25:0] t;
        logic [14:0] pw;
        int          pick;
        int          nudge;
        pick  = $urandom_range(0, 99);
        nudge = $urandom_range(0, 4);
        nudge = nudge - 2;
        if (pick < 70)
            md = MODE_PLAN;
        else if (pick < 88)
            md = MODE_RELEASE;
        else if (pick < 95)
            md = MODE_FAULT;
        else
            md = MODE_SPARE;
        case ($urandom_range(0, 3))
            0:       t = 26'($urandom);
            1:       t = clip_us(longint'(phase_end($urandom_range(0, 4))) + nudge);
            default: t = clip_us($urandom_range(0, 32'(phase_end(4)) + 1000));
        endcase
        pw = $urandom_range(0, 1) ? 15'($urandom) : 15'($urandom_range(0, 16384));
        send_item(md, t, pw, $urandom);
    endtask

    // Bursts of random length, some followed by a gap and some run straight on.
    task automatic random_run(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && left > 0)
            begin
                random_item();
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                pause_items($urandom_range(0, 9));
        end
        pause_items(0);
    endtask

    initial
    begin
        cfg_t rnd;
        int   k;
        int   spin;
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = '0;
        elapsed_us  = '0;
        prev_weight = '0;
        sequence_in = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        plan        = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // The registers still hold their reset values here.
        random_run(4);

        load_setting('{15'd16384, 13'd6554, 24'd5856371, 23'd6710886,
                       21'd2000000, 25'd2499924, 25'd872667});
        for (k = 0; k < 5; k++)
        begin
            send_item(MODE_PLAN, clip_us(longint'(phase_end(k)) - 1), 15'd0, $urandom);
            send_item(MODE_PLAN, clip_us(phase_end(k)), 15'h7fff, $urandom);
        end
        send_item(MODE_PLAN, 26'd0, 15'd0, 32'd0);
        send_item(MODE_PLAN, '1, '1, '1);
        send_item(MODE_RELEASE, 26'd0, 15'd16384, 32'd0);
        send_item(MODE_RELEASE, '1, 15'd16384, '1);
        send_item(MODE_RELEASE, 26'd1000000, 15'h7fff, $urandom);
        send_item(MODE_RELEASE, 26'd0, 15'd0, $urandom);
        send_item(MODE_RELEASE, 26'd2000, 15'd1, $urandom);
        send_item(MODE_FAULT, '1, '1, '1);
        send_item(MODE_FAULT, 26'd0, 15'd0, 32'd0);
        send_item(MODE_SPARE, 26'($urandom), 15'($urandom), $urandom);
        pause_items(4);
        random_run(70);

        load_setting('{15'd16384, 13'd6554, -24'sd5856371, 23'd6710886,
                       21'd2000000, 25'd30000000, 25'd30000000});
        random_run(60);

        // The move is far too short to reach the offset, so the hold step is abrupt.
        load_setting('{15'd10000, 13'd4000, -24'sd300000, 23'd2000000,
                       21'd1000, 25'd40000, 25'd30000});
        random_run(60);

        // No ramp and no hold: those phases are skipped.
        load_setting('{15'd20000, 13'd3000, 24'd123456, 23'd500000,
                       21'd0, 25'd0, 25'd5000});
        random_run(60);

        load_setting('{'1, '1, 24'h800000, '1, '1, '1, '1});
        random_run(60);

        load_setting('{15'd0, 13'd6554, 24'd1, 23'd1, 21'd1, 25'd1, 25'd1});
        random_run(40);

        repeat (2)
        begin
            rnd.peak_weight  = 15'($urandom);
            rnd.weight_rate  = 13'($urandom);
            rnd.joint_offset = 24'($urandom);
            rnd.max_velocity = 23'($urandom);
            rnd.hold_time_us = 21'($urandom);
            rnd.ramp_time_us = 25'($urandom);
            rnd.move_time_us = 25'($urandom);
            load_setting(rnd);
            random_run(50);
        end

        spin = 0;
        while (outstanding != 0 && spin < 1000)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (10) @(negedge clk);
        if (outstanding != 0)
            $error("%0d frames never arrived", outstanding);
        $display("Run covered %0d items in all modes under %0d register settings (%0d writes),",
                 items_sent, settings_loaded, writes_done);
        $display("with elapsed times aimed at every phase boundary and at the extremes.");
        if (mismatches == 0 && outstanding == 0)
            $display("tb_ramp_move_hold_profile_sampler: clean");
        else
            $display("tb_ramp_move_hold_profile_sampler: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_ramp_move_hold_profile_sampler: errors");
        $finish;
    end

endmodule
